FILE: hw/rtl/indexed_max_heap_queue_top_defines.svh
// Assertion macros for the indexed max-heap queue.
// Users must provide clk and rst in scope.
`ifndef INDEXED_MAX_HEAP_QUEUE_TOP_DEFINES_SVH
`define INDEXED_MAX_HEAP_QUEUE_TOP_DEFINES_SVH

`define IHQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define IHQ_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/ihq_pkg.sv
// Shared constants, types and the heap ordering function.
// No dependencies.
`default_nettype none
package ihq_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ID_SPACE    = 256;
  localparam int ID_W        = 8;
  localparam int KEY_W       = 32;
  localparam int AMT_W       = 31;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ACC_W       = AMT_W + CNT_W;

  localparam logic [2:0] CMD_INSERT  = 3'd0;
  localparam logic [2:0] CMD_DELETE  = 3'd1;
  localparam logic [2:0] CMD_RAISE   = 3'd2;
  localparam logic [2:0] CMD_LOWER   = 3'd3;
  localparam logic [2:0] CMD_CONSUME = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_ID    = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic signed [KEY_W-1:0] key;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } slot_req_t;

  typedef struct packed {
    logic             we;
    logic [ID_W-1:0]  waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [ID_W-1:0]  raddr;
  } pos_req_t;

  typedef struct packed {
    logic [ID_W-1:0]         top_id;
    logic signed [KEY_W-1:0] top_key;
    logic                    queue_empty;
    logic signed [KEY_W-1:0] value;
    logic [1:0]              status;
  } res_t;

  // higher key wins; equal keys go to the higher id
  function automatic logic ranks_above(slot_t a, slot_t b);
    if (a.key != b.key) return a.key > b.key;
    return a.id > b.id;
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/ihq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module ihq_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ihq_core.sv
// Heap sequencer: command decode, sift engine, consume sweeps, id presence.
// Depends on ihq_pkg and indexed_max_heap_queue_top_defines.svh.
`default_nettype none
`include "indexed_max_heap_queue_top_defines.svh"
module ihq_core
  import ihq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire logic [2:0]       command,
  input  wire logic [ID_W-1:0]  entry_id,
  input  wire logic [AMT_W-1:0] amount,
  output      slot_req_t        slot_req,
  input  wire slot_t            slot_rdata,
  output      pos_req_t         pos_req,
  input  wire logic [IDX_W-1:0] pos_rdata,
  output      logic             res_valid,
  input  wire logic             res_ready,
  output      res_t             res
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DEL_P   = 5'd1;
  localparam logic [4:0] S_DEL_L   = 5'd2;
  localparam logic [4:0] S_RL_P    = 5'd3;
  localparam logic [4:0] S_RL_S    = 5'd4;
  localparam logic [4:0] S_SU_CHK  = 5'd5;
  localparam logic [4:0] S_SU_RD   = 5'd6;
  localparam logic [4:0] S_SD_CHK  = 5'd7;
  localparam logic [4:0] S_SD_RL   = 5'd8;
  localparam logic [4:0] S_SD_RR   = 5'd9;
  localparam logic [4:0] S_SD_DEC  = 5'd10;
  localparam logic [4:0] S_SWP     = 5'd11;
  localparam logic [4:0] S_SR_SET  = 5'd12;
  localparam logic [4:0] S_DEC_CHK = 5'd13;
  localparam logic [4:0] S_DEC_P   = 5'd14;
  localparam logic [4:0] S_DEC_S   = 5'd15;
  localparam logic [4:0] S_HP_INIT = 5'd16;
  localparam logic [4:0] S_HP_LD   = 5'd17;
  localparam logic [4:0] S_HP_LD2  = 5'd18;
  localparam logic [4:0] S_TOP     = 5'd19;
  localparam logic [4:0] S_TOP_RD  = 5'd20;

  localparam logic [1:0] PH_SUM   = 2'd0;
  localparam logic [1:0] PH_COST  = 2'd1;
  localparam logic [1:0] PH_CLAMP = 2'd2;

  logic [4:0]          state, state_next;
  logic [CNT_W-1:0]    cnt, cnt_next;
  logic [ID_SPACE-1:0] present, present_next;
  slot_t               e, e_next, lreg, lreg_next, rreg, rreg_next;
  logic [IDX_W-1:0]    i, i_next, hz, hz_next, sw_j, sw_j_next, dpos, dpos_next;
  logic [ID_W-1:0]     cmd_id, cmd_id_next, did, did_next;
  logic [2:0]          cmd_q, cmd_q_next;
  logic                moved, moved_next, then_down, then_down_next;
  logic                heap_mode, heap_mode_next, has_r, has_r_next;
  logic                final_pass, final_pass_next, sw_v, sw_v_next;
  logic [AMT_W-1:0]    units, units_next, maxkey, maxkey_next, taken, taken_next;
  logic [AMT_W-1:0]    lo, lo_next, hi, hi_next, mid, mid_next, rest, rest_next;
  logic [ACC_W-1:0]    sumpos, sumpos_next, cost, cost_next;
  logic [CNT_W-1:0]    sw_a, sw_a_next;
  logic [1:0]          phase, phase_next;
  logic [1:0]          res_status, res_status_next;
  logic signed [KEY_W-1:0] res_value, res_value_next;

  logic                    do_fin, id_ok, known, pick_r;
  logic [IDX_W-1:0]        parent, bidx;
  logic [IDX_W+1:0]        lidx, ridx, cnt_x;
  slot_t                   best;
  logic signed [KEY_W:0]   ksum;
  logic signed [KEY_W-1:0] ksat, lo_key, mid_key;
  logic [AMT_W-1:0]        tk;

  assign id_ok   = 32'(entry_id) < ID_SPACE;
  assign known   = id_ok && present[entry_id];
  assign parent  = (i - IDX_W'(1)) >> 1;
  assign lidx    = {1'b0, i, 1'b1};
  assign ridx    = lidx + (IDX_W+2)'(1);
  assign cnt_x   = (IDX_W+2)'(cnt);
  assign pick_r  = has_r && ranks_above(rreg, lreg);
  assign best    = pick_r ? rreg : lreg;
  assign bidx    = pick_r ? ridx[IDX_W-1:0] : lidx[IDX_W-1:0];
  assign lo_key  = $signed({1'b0, lo});
  assign mid_key = $signed({1'b0, mid});
  assign tk      = (ACC_W'(units) < sumpos) ? units : sumpos[AMT_W-1:0];
  assign ksum    = (cmd_q == CMD_RAISE) ?
                   {slot_rdata.key[KEY_W-1], slot_rdata.key} + $signed({2'b00, units}) :
                   {slot_rdata.key[KEY_W-1], slot_rdata.key} - $signed({2'b00, units});
  assign ksat    = (ksum[KEY_W] != ksum[KEY_W-1]) ?
                   (ksum[KEY_W] ? {1'b1, {(KEY_W-1){1'b0}}} : {1'b0, {(KEY_W-1){1'b1}}}) :
                   ksum[KEY_W-1:0];
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    present_next    = present;
    e_next          = e;
    lreg_next       = lreg;
    rreg_next       = rreg;
    i_next          = i;
    hz_next         = hz;
    sw_j_next       = sw_j;
    dpos_next       = dpos;
    cmd_id_next     = cmd_id;
    did_next        = did;
    cmd_q_next      = cmd_q;
    moved_next      = moved;
    then_down_next  = then_down;
    heap_mode_next  = heap_mode;
    has_r_next      = has_r;
    final_pass_next = final_pass;
    sw_v_next       = sw_v;
    units_next      = units;
    maxkey_next     = maxkey;
    taken_next      = taken;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    rest_next       = rest;
    sumpos_next     = sumpos;
    cost_next       = cost;
    sw_a_next       = sw_a;
    phase_next      = phase;
    res_status_next = res_status;
    res_value_next  = res_value;
    slot_req        = '0;
    pos_req         = '0;
    res_valid       = 1'b0;
    do_fin          = 1'b0;

    res.queue_empty = (cnt == '0);
    res.top_id      = (cnt == '0) ? '0 : slot_rdata.id;
    res.top_key     = (cnt == '0) ? '0 : slot_rdata.key;
    res.value       = res_value;
    res.status      = res_status;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = ST_OK;
          res_value_next  = '0;
          cmd_id_next     = entry_id;
          cmd_q_next      = command;
          units_next      = amount;
          heap_mode_next  = 1'b0;
          moved_next      = 1'b0;
          then_down_next  = 1'b0;
          state_next      = S_TOP;
          case (command)
            CMD_INSERT: begin
              if (!id_ok || present[entry_id]) begin
                res_status_next = ST_ID;
              end else if (cnt >= CNT_W'(MAX_ENTRIES)) begin
                res_status_next = ST_FULL;
              end else begin
                e_next.id              = entry_id;
                e_next.key             = $signed({1'b0, amount});
                i_next                 = cnt[IDX_W-1:0];
                cnt_next               = cnt + CNT_W'(1);
                present_next[entry_id] = 1'b1;
                state_next             = S_SU_CHK;
              end
            end
            CMD_DELETE: begin
              if (!known) begin
                res_status_next = ST_ID;
              end else begin
                pos_req.re             = 1'b1;
                pos_req.raddr          = entry_id;
                present_next[entry_id] = 1'b0;
                cnt_next               = cnt - CNT_W'(1);
                state_next             = S_DEL_P;
              end
            end
            CMD_RAISE, CMD_LOWER: begin
              if (!known) begin
                res_status_next = ST_ID;
              end else begin
                pos_req.re    = 1'b1;
                pos_req.raddr = entry_id;
                state_next    = S_RL_P;
              end
            end
            CMD_CONSUME: begin
              if (cnt == '0) begin
                res_status_next = ST_EMPTY;
              end else begin
                sumpos_next = '0;
                maxkey_next = '0;
                sw_a_next   = '0;
                sw_v_next   = 1'b0;
                phase_next  = PH_SUM;
                state_next  = S_SWP;
              end
            end
            default: state_next = S_TOP;
          endcase
        end
      end
      S_DEL_P: begin
        i_next = pos_rdata;
        if (CNT_W'(pos_rdata) == cnt) begin
          state_next = S_TOP;
        end else begin
          slot_req.re    = 1'b1;
          slot_req.raddr = cnt[IDX_W-1:0];
          state_next     = S_DEL_L;
        end
      end
      S_DEL_L: begin
        e_next         = slot_rdata;
        then_down_next = 1'b1;
        state_next     = S_SU_CHK;
      end
      S_RL_P: begin
        i_next         = pos_rdata;
        slot_req.re    = 1'b1;
        slot_req.raddr = pos_rdata;
        state_next     = S_RL_S;
      end
      S_RL_S: begin
        e_next.id      = cmd_id;
        e_next.key     = ksat;
        res_value_next = ksat;
        state_next     = (cmd_q == CMD_RAISE) ? S_SU_CHK : S_SD_CHK;
      end
      S_SU_CHK: begin
        if (i == '0) begin
          if (then_down && !moved) state_next = S_SD_CHK;
          else do_fin = 1'b1;
        end else begin
          slot_req.re    = 1'b1;
          slot_req.raddr = parent;
          state_next     = S_SU_RD;
        end
      end
      S_SU_RD: begin
        if (ranks_above(e, slot_rdata)) begin
          slot_req.we    = 1'b1;
          slot_req.waddr = i;
          slot_req.wdata = slot_rdata;
          pos_req.we     = 1'b1;
          pos_req.waddr  = slot_rdata.id;
          pos_req.wdata  = i;
          i_next         = parent;
          moved_next     = 1'b1;
          state_next     = S_SU_CHK;
        end else if (then_down && !moved) begin
          state_next = S_SD_CHK;
        end else begin
          do_fin = 1'b1;
        end
      end
      S_SD_CHK: begin
        if (lidx >= cnt_x) begin
          do_fin = 1'b1;
        end else begin
          slot_req.re    = 1'b1;
          slot_req.raddr = lidx[IDX_W-1:0];
          state_next     = S_SD_RL;
        end
      end
      S_SD_RL: begin
        lreg_next = slot_rdata;
        if (ridx < cnt_x) begin
          slot_req.re    = 1'b1;
          slot_req.raddr = ridx[IDX_W-1:0];
          has_r_next     = 1'b1;
          state_next     = S_SD_RR;
        end else begin
          has_r_next = 1'b0;
          state_next = S_SD_DEC;
        end
      end
      S_SD_RR: begin
        rreg_next  = slot_rdata;
        state_next = S_SD_DEC;
      end
      S_SD_DEC: begin
        if (ranks_above(best, e)) begin
          slot_req.we    = 1'b1;
          slot_req.waddr = i;
          slot_req.wdata = best;
          pos_req.we     = 1'b1;
          pos_req.waddr  = best.id;
          pos_req.wdata  = i;
          i_next         = bidx;
          state_next     = S_SD_CHK;
        end else begin
          do_fin = 1'b1;
        end
      end
      S_SWP: begin
        if (sw_a < cnt) begin
          slot_req.re    = 1'b1;
          slot_req.raddr = sw_a[IDX_W-1:0];
          sw_a_next      = sw_a + CNT_W'(1);
          sw_j_next      = sw_a[IDX_W-1:0];
          sw_v_next      = 1'b1;
        end else begin
          sw_v_next = 1'b0;
        end
        if (sw_v) begin
          case (phase)
            PH_SUM: begin
              if (slot_rdata.key > 0) begin
                sumpos_next = sumpos + ACC_W'(slot_rdata.key[AMT_W-1:0]);
              end
              if (slot_rdata.key > $signed({1'b0, maxkey})) begin
                maxkey_next = slot_rdata.key[AMT_W-1:0];
              end
            end
            PH_COST: begin
              if (slot_rdata.key > mid_key) begin
                cost_next = cost + ACC_W'(slot_rdata.key - mid_key);
              end
            end
            PH_CLAMP: begin
              if (slot_rdata.key > lo_key) begin
                slot_req.we        = 1'b1;
                slot_req.waddr     = sw_j;
                slot_req.wdata.id  = slot_rdata.id;
                slot_req.wdata.key = lo_key;
              end
            end
            default: ;
          endcase
        end else if (sw_a == cnt) begin
          case (phase)
            PH_SUM: begin
              taken_next     = tk;
              res_value_next = KEY_W'(tk);
              if (tk == '0) begin
                state_next = S_TOP;
              end else begin
                lo_next    = '0;
                hi_next    = maxkey;
                state_next = S_SR_SET;
              end
            end
            PH_COST: begin
              if (final_pass) begin
                rest_next  = taken - cost[AMT_W-1:0];
                sw_a_next  = '0;
                phase_next = PH_CLAMP;
              end else begin
                if (cost <= ACC_W'(taken)) hi_next = mid;
                else lo_next = mid + AMT_W'(1);
                state_next = S_SR_SET;
              end
            end
            default: begin
              did_next   = ID_W'(ID_SPACE - 1);
              state_next = S_DEC_CHK;
            end
          endcase
        end
      end
      S_SR_SET: begin
        if (lo < hi) begin
          mid_next        = AMT_W'(((AMT_W+1)'(lo) + (AMT_W+1)'(hi)) >> 1);
          final_pass_next = 1'b0;
        end else begin
          mid_next        = lo;
          final_pass_next = 1'b1;
        end
        cost_next  = '0;
        sw_a_next  = '0;
        sw_v_next  = 1'b0;
        phase_next = PH_COST;
        state_next = S_SWP;
      end
      S_DEC_CHK: begin
        if (rest == '0) begin
          state_next = S_HP_INIT;
        end else if (present[did]) begin
          pos_req.re    = 1'b1;
          pos_req.raddr = did;
          state_next    = S_DEC_P;
        end else if (did == '0) begin
          state_next = S_HP_INIT;
        end else begin
          did_next = did - ID_W'(1);
        end
      end
      S_DEC_P: begin
        dpos_next      = pos_rdata;
        slot_req.re    = 1'b1;
        slot_req.raddr = pos_rdata;
        state_next     = S_DEC_S;
      end
      S_DEC_S: begin
        if (slot_rdata.key == lo_key) begin
          slot_req.we        = 1'b1;
          slot_req.waddr     = dpos;
          slot_req.wdata.id  = slot_rdata.id;
          slot_req.wdata.key = lo_key - KEY_W'(1);
          rest_next          = rest - AMT_W'(1);
        end
        if (did == '0) begin
          state_next = S_HP_INIT;
        end else begin
          did_next   = did - ID_W'(1);
          state_next = S_DEC_CHK;
        end
      end
      S_HP_INIT: begin
        heap_mode_next = 1'b1;
        if (cnt < CNT_W'(2)) begin
          state_next = S_TOP;
        end else begin
          hz_next    = IDX_W'((cnt >> 1) - CNT_W'(1));
          state_next = S_HP_LD;
        end
      end
      S_HP_LD: begin
        slot_req.re    = 1'b1;
        slot_req.raddr = hz;
        state_next     = S_HP_LD2;
      end
      S_HP_LD2: begin
        e_next     = slot_rdata;
        i_next     = hz;
        state_next = S_SD_CHK;
      end
      S_TOP: begin
        slot_req.re    = 1'b1;
        slot_req.raddr = '0;
        state_next     = S_TOP_RD;
      end
      S_TOP_RD: begin
        res_valid = 1'b1;
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase

    // place the held item in the hole and leave the sift
    if (do_fin) begin
      slot_req.we    = 1'b1;
      slot_req.waddr = i;
      slot_req.wdata = e;
      pos_req.we     = 1'b1;
      pos_req.waddr  = e.id;
      pos_req.wdata  = i;
      if (heap_mode && hz != '0) begin
        hz_next    = hz - IDX_W'(1);
        state_next = S_HP_LD;
      end else begin
        state_next = S_TOP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cnt     <= '0;
      present <= '0;
    end else begin
      state   <= state_next;
      cnt     <= cnt_next;
      present <= present_next;
    end
  end

  always_ff @(posedge clk) begin
    e          <= e_next;
    lreg       <= lreg_next;
    rreg       <= rreg_next;
    i          <= i_next;
    hz         <= hz_next;
    sw_j       <= sw_j_next;
    dpos       <= dpos_next;
    cmd_id     <= cmd_id_next;
    did        <= did_next;
    cmd_q      <= cmd_q_next;
    moved      <= moved_next;
    then_down  <= then_down_next;
    heap_mode  <= heap_mode_next;
    has_r      <= has_r_next;
    final_pass <= final_pass_next;
    sw_v       <= sw_v_next;
    units      <= units_next;
    maxkey     <= maxkey_next;
    taken      <= taken_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    rest       <= rest_next;
    sumpos     <= sumpos_next;
    cost       <= cost_next;
    sw_a       <= sw_a_next;
    phase      <= phase_next;
    res_status <= res_status_next;
    res_value  <= res_value_next;
  end

  `IHQ_ASSERT(a_cnt_range, cnt <= CNT_W'(MAX_ENTRIES), "entry count above capacity")
  `IHQ_ASSERT(a_wr_in_heap, slot_req.we |-> CNT_W'(slot_req.waddr) < cnt, "slot write beyond heap")
  `IHQ_ASSERT_NEVER(a_rw_clash, slot_req.we && slot_req.re && slot_req.waddr == slot_req.raddr, "slot read and write collide")
  `IHQ_ASSERT(a_one_item, (in_valid && in_ready) |=> !in_ready, "second item taken while busy")

endmodule
`default_nettype wire

FILE: hw/rtl/indexed_max_heap_queue_top.sv
// Indexed max-heap queue top: slot and position memories, sequencer, result register.
// Depends on ihq_pkg, ihq_ram and ihq_core.
//
// Input channel (in_valid/in_ready) takes one command item: command, entry_id,
// amount. Output channel (out_valid/out_ready) returns exactly one result item
// per command: top_id, top_key, queue_empty, value, status.
// Items are handled one at a time; in_ready is high only while the sequencer
// is idle. Insert and raise sift the entry up and lower sifts it down.
// Delete moves the last entry into the freed slot, unless the deleted entry
// was the last, and sifts it up or, if it did not move, down. Errors go
// straight to the result. Consume runs a sum sweep, a binary search of cost
// sweeps over the key range, a clamp sweep, a spread of the remaining units
// over the ids, then a heap rebuild of about entries/2 sift-downs.
// A finished result sits in the output register; the next item can be
// accepted while it waits, but the following result holds the sequencer
// until the receiver takes the earlier one.
// Reset (rst, synchronous) empties the heap and clears all presence bits;
// no clearing pass runs, so the block is ready the cycle after reset.
`default_nettype none
module indexed_max_heap_queue_top
  import ihq_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire logic [2:0]              command,
  input  wire logic [ID_W-1:0]         entry_id,
  input  wire logic [AMT_W-1:0]        amount,
  output      logic                    out_valid,
  input  wire logic                    out_ready,
  output      logic [ID_W-1:0]         top_id,
  output      logic signed [KEY_W-1:0] top_key,
  output      logic                    queue_empty,
  output      logic signed [KEY_W-1:0] value,
  output      logic [1:0]              status
);

  slot_req_t        slot_req;
  slot_t            slot_rdata;
  pos_req_t         pos_req;
  logic [IDX_W-1:0] pos_rdata;
  logic             res_valid, res_ready;
  res_t             res;

  ihq_core u_core (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .entry_id   (entry_id),
    .amount     (amount),
    .slot_req   (slot_req),
    .slot_rdata (slot_rdata),
    .pos_req    (pos_req),
    .pos_rdata  (pos_rdata),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  ihq_ram #(.DEPTH(MAX_ENTRIES), .WIDTH($bits(slot_t))) u_slot_ram (
    .clk   (clk),
    .we    (slot_req.we),
    .waddr (slot_req.waddr),
    .wdata (slot_req.wdata),
    .re    (slot_req.re),
    .raddr (slot_req.raddr),
    .rdata (slot_rdata)
  );

  ihq_ram #(.DEPTH(ID_SPACE), .WIDTH(IDX_W)) u_pos_ram (
    .clk   (clk),
    .we    (pos_req.we),
    .waddr (pos_req.waddr),
    .wdata (pos_req.wdata),
    .re    (pos_req.re),
    .raddr (pos_req.raddr),
    .rdata (pos_rdata)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      top_id      <= res.top_id;
      top_key     <= res.top_key;
      queue_empty <= res.queue_empty;
      value       <= res.value;
      status      <= res.status;
    end
  end

endmodule
`default_nettype wire
